>>> rtl/sdt_pkg.sv
// Shared types and constants for the stereo triangulation block.
// No dependencies; every other file imports this package.
package sdt_pkg;

   localparam int PIXEL_BITS = 12;
   localparam int DISP_W     = 12;
   localparam int CFG_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int MAG_W      = (PIXEL_BITS + 4 > CFG_W) ? PIXEL_BITS + 4 : CFG_W;
   localparam int PROD_W     = MAG_W + CFG_W;

   // divider: quotient bits kept, bits resolved per stage, stage count
   localparam int Q_W        = 33;
   localparam int DIV_STEP   = 3;
   localparam int DIV_STAGES = Q_W / DIV_STEP;
   localparam int DIV_LAT    = DIV_STAGES + 1;

   // result queue
   localparam int QDEPTH     = 32;
   localparam int QPTR_W     = 5;
   localparam int QCNT_W     = 6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_C = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_R = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BASELINE = 2'd3;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_col;
      logic [PIXEL_BITS-1:0] pixel_row;
      logic [DISP_W-1:0]     disparity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [30:0]        point_z;
      logic               point_valid;
      logic               saturated;
   } rsp_type;

   // front to back
   typedef struct packed {
      logic              valid;
      logic              zero;
      logic              neg_x;
      logic              neg_y;
      logic [DISP_W-1:0] disp;
      logic [PROD_W-1:0] prod_x;
      logic [PROD_W-1:0] prod_y;
      logic [PROD_W-1:0] prod_z;
   } fe_type;

endpackage

>>> rtl/sdt_front.sv
// Front end: configuration registers, center offset and baseline products.
// Depends on sdt_pkg.
module sdt_front
   import sdt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 accept,
   input  req_type              item,
   output fe_type               fe_out
);

   logic [CFG_W-1:0] focal_ff, ccol_ff, crow_ff, base_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= '0;
         ccol_ff  <= '0;
         crow_ff  <= '0;
         base_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_FOCAL:    focal_ff <= csr_wdata;
            REG_CENTER_C: ccol_ff  <= csr_wdata;
            REG_CENTER_R: crow_ff  <= csr_wdata;
            REG_BASELINE: base_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: signed offset from the principal point, as sign and magnitude
   logic [MAG_W-1:0] scol_in, srow_in, cc_in, cr_in;
   logic             negx_in, negy_in;
   logic [MAG_W-1:0] magx_in, magy_in;

   always_comb begin
      scol_in = MAG_W'({item.pixel_col, 4'b0});
      srow_in = MAG_W'({item.pixel_row, 4'b0});
      cc_in   = MAG_W'(ccol_ff);
      cr_in   = MAG_W'(crow_ff);
      negx_in = cc_in > scol_in;
      negy_in = cr_in > srow_in;
      magx_in = negx_in ? cc_in - scol_in : scol_in - cc_in;
      magy_in = negy_in ? cr_in - srow_in : srow_in - cr_in;
   end

   logic              v1_ff;
   logic              zero1_ff, negx1_ff, negy1_ff;
   logic [MAG_W-1:0]  magx1_ff, magy1_ff;
   logic [DISP_W-1:0] disp1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= accept;
   end

   always_ff @(posedge clock) begin
      zero1_ff <= (item.disparity == '0);
      negx1_ff <= negx_in;
      negy1_ff <= negy_in;
      magx1_ff <= magx_in;
      magy1_ff <= magy_in;
      disp1_ff <= item.disparity;
   end

   // stage 2: products with the baseline
   logic v2_ff;
   fe_type s2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      s2_ff.valid  <= 1'b0;
      s2_ff.zero   <= zero1_ff;
      s2_ff.neg_x  <= negx1_ff;
      s2_ff.neg_y  <= negy1_ff;
      s2_ff.disp   <= disp1_ff;
      s2_ff.prod_x <= PROD_W'(magx1_ff * base_ff);
      s2_ff.prod_y <= PROD_W'(magy1_ff * base_ff);
      s2_ff.prod_z <= PROD_W'(focal_ff * base_ff);
   end

   always_comb begin
      fe_out       = s2_ff;
      fe_out.valid = v2_ff;
   end

endmodule

>>> rtl/sdt_div.sv
// Pipelined restoring divider with overflow flag, DIV_STEP quotient bits per stage.
// Depends on sdt_pkg.
module sdt_div
   import sdt_pkg::*;
#(
   parameter int SHIFT = 8
) (
   input  logic              clock,
   input  logic [PROD_W-1:0] num,
   input  logic [DISP_W-1:0] den,
   output logic [Q_W-1:0]    quo,
   output logic              ovf
);

   localparam int NUM_W = PROD_W + SHIFT;
   localparam int HI_W  = NUM_W - Q_W;
   localparam int CMP_W = (HI_W > DISP_W) ? HI_W : DISP_W;

   logic [DISP_W-1:0] rem_ff [0:DIV_STAGES];
   logic [Q_W-1:0]    low_ff [0:DIV_STAGES];
   logic [Q_W-1:0]    q_ff   [0:DIV_STAGES];
   logic              ovf_ff [0:DIV_STAGES];
   logic [DISP_W-1:0] den_ff [0:DIV_STAGES];

   // entry: quotient of 2^Q_W or more is flagged, else remainder starts at the top bits
   logic [NUM_W-1:0] nfull;
   logic [HI_W-1:0]  hi;
   logic             ovf_in;

   always_comb begin
      nfull  = {num, SHIFT'(0)};
      hi     = nfull[NUM_W-1:Q_W];
      ovf_in = CMP_W'(hi) >= CMP_W'(den);
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= ovf_in ? '0 : DISP_W'(hi);
      low_ff[0] <= nfull[Q_W-1:0];
      q_ff[0]   <= '0;
      ovf_ff[0] <= ovf_in;
      den_ff[0] <= den;
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [DISP_W:0]   r;
      logic [Q_W-1:0]    lw, qq;

      // DIV_STEP long-division steps
      always_comb begin
         r  = {1'b0, rem_ff[s]};
         lw = low_ff[s];
         qq = q_ff[s];
         for (int j = 0; j < DIV_STEP; j++) begin
            r  = {r[DISP_W-1:0], lw[Q_W-1]};
            lw = {lw[Q_W-2:0], 1'b0};
            if (r >= {1'b0, den_ff[s]}) begin
               r  = r - {1'b0, den_ff[s]};
               qq = {qq[Q_W-2:0], 1'b1};
            end else begin
               qq = {qq[Q_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s+1] <= r[DISP_W-1:0];
         low_ff[s+1] <= lw;
         q_ff[s+1]   <= qq;
         ovf_ff[s+1] <= ovf_ff[s];
         den_ff[s+1] <= den_ff[s];
      end
   end

   assign quo = q_ff[DIV_STAGES];
   assign ovf = ovf_ff[DIV_STAGES];

endmodule

>>> rtl/sdt_back.sv
// Back end: three divider lanes, flag delay line, saturation and sign.
// Depends on sdt_pkg and sdt_div.
module sdt_back
   import sdt_pkg::*;
#(
   parameter int DISP_FRAC_BITS = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  fe_type  fe_in,
   output logic    out_valid,
   output rsp_type out_item
);

   localparam int SHIFT = DISP_FRAC_BITS + 4;

   logic [Q_W-1:0] qx, qy, qz;
   logic           ox, oy, oz;

   sdt_div #(.SHIFT(SHIFT)) u_div_x (
      .clock(clock), .num(fe_in.prod_x), .den(fe_in.disp), .quo(qx), .ovf(ox));
   sdt_div #(.SHIFT(SHIFT)) u_div_y (
      .clock(clock), .num(fe_in.prod_y), .den(fe_in.disp), .quo(qy), .ovf(oy));
   sdt_div #(.SHIFT(SHIFT)) u_div_z (
      .clock(clock), .num(fe_in.prod_z), .den(fe_in.disp), .quo(qz), .ovf(oz));

   // flags ride alongside the dividers
   logic vld_ff  [0:DIV_LAT];
   logic zero_ff [0:DIV_LAT];
   logic negx_ff [0:DIV_LAT];
   logic negy_ff [0:DIV_LAT];

   always_comb begin
      vld_ff[0]  = fe_in.valid;
      zero_ff[0] = fe_in.zero;
      negx_ff[0] = fe_in.neg_x;
      negy_ff[0] = fe_in.neg_y;
   end

   for (genvar k = 0; k < DIV_LAT; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) vld_ff[k+1] <= 1'b0;
         else       vld_ff[k+1] <= vld_ff[k];
      end
      always_ff @(posedge clock) begin
         zero_ff[k+1] <= zero_ff[k];
         negx_ff[k+1] <= negx_ff[k];
         negy_ff[k+1] <= negy_ff[k];
      end
   end

   // clamp one lateral quotient and apply its sign
   function automatic logic [32:0] lat_sat(input logic [Q_W-1:0] q, input logic o,
                                           input logic neg);
      logic s;
      logic [31:0] v;
      if (neg) begin
         s = o | q[32] | (q[31] & (|q[30:0]));
         v = s ? 32'h8000_0000 : 32'd0 - q[31:0];
      end else begin
         s = o | q[32] | q[31];
         v = s ? 32'h7FFF_FFFF : q[31:0];
      end
      return {s, v};
   endfunction

   logic [32:0] rx, ry;
   logic        sz;
   rsp_type     res_in;

   always_comb begin
      rx = lat_sat(qx, ox, negx_ff[DIV_LAT]);
      ry = lat_sat(qy, oy, negy_ff[DIV_LAT]);
      sz = oz | qz[32] | qz[31];
      if (zero_ff[DIV_LAT]) begin
         res_in = '0;
      end else begin
         res_in.point_x     = rx[31:0];
         res_in.point_y     = ry[31:0];
         res_in.point_z     = sz ? 31'h7FFF_FFFF : qz[30:0];
         res_in.point_valid = 1'b1;
         res_in.saturated   = rx[32] | ry[32] | sz;
      end
   end

   // output register
   logic    ov_ff;
   rsp_type res_ff;

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else       ov_ff <= vld_ff[DIV_LAT];
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign out_valid = ov_ff;
   assign out_item  = res_ff;

endmodule

>>> rtl/sdt_queue.sv
// Result queue of QDEPTH items.
// Depends on sdt_pkg.
module sdt_queue
   import sdt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type wdata,
   input  logic    pop,
   output logic    empty,
   output rsp_type rdata
);

   rsp_type            mem_ff [0:QDEPTH-1];
   logic [QPTR_W-1:0]  wp_ff, rp_ff;
   logic [QCNT_W-1:0]  cnt_ff;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wdata;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   assign empty = (cnt_ff == '0);
   assign rdata = mem_ff[rp_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != QCNT_W'(QDEPTH)))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");
   a_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("queue count out of range");

endmodule

>>> rtl/stereo_disparity_triangulation.sv
// Top level of the stereo disparity triangulation block.
// Depends on sdt_pkg, sdt_front, sdt_back, sdt_queue.
//
// Usage:
//  - req_*: queue-style input. An item (column, row, disparity) is taken at a
//    clock edge with req_push high and req_full low.
//  - rsp_*: queue-style output. The oldest point sits on rsp_item while
//    rsp_empty is low and leaves at an edge with rsp_pop high.
//  - csr_*: write-only registers (focal length, center column, center row,
//    baseline), written whenever csr_we is high; write only while idle.
//  - Throughput: one item per cycle while req_full is low. From accept to
//    rsp_empty low, an item passes the offset stage (loaded at the accepting
//    edge), the baseline multiply, the divider entry register and its 11 stages
//    of three quotient bits each, an output register and the queue write.
//  - An occupancy count covers items in flight plus queued results; req_full
//    rises once 32 items are outstanding, so a stalled receiver holds the
//    input off without losing anything in the pipeline.
//  - Reset (synchronous) clears the configuration registers, valid flags and counters to zero and empties the block.
module stereo_disparity_triangulation
   import sdt_pkg::*;
#(
   parameter int DISP_FRAC_BITS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_item,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   logic    accept, take;
   fe_type  fe;
   logic    bk_valid;
   rsp_type bk_item;
   logic [QCNT_W-1:0] occ_ff;

   assign accept = req_push & ~req_full;
   assign take   = rsp_pop & ~rsp_empty;

   sdt_front u_front (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .accept(accept), .item(req_item), .fe_out(fe));

   sdt_back #(.DISP_FRAC_BITS(DISP_FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .fe_in(fe),
      .out_valid(bk_valid), .out_item(bk_item));

   sdt_queue u_queue (
      .clock(clock), .reset(reset),
      .push(bk_valid), .wdata(bk_item),
      .pop(take), .empty(rsp_empty), .rdata(rsp_item));

   // outstanding items: in flight plus queued
   always_ff @(posedge clock) begin
      if (reset) occ_ff <= '0;
      else       occ_ff <= occ_ff + QCNT_W'(accept) - QCNT_W'(take);
   end

   assign req_full = (occ_ff == QCNT_W'(QDEPTH));

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= QCNT_W'(QDEPTH))
      else $error("occupancy out of range");
   a_occ_inc: assert property (@(posedge clock) disable iff (reset)
      accept && !take |=> occ_ff == $past(occ_ff) + 1'b1)
      else $error("occupancy missed an accept");
   a_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> rsp_empty)
      else $error("result present with nothing outstanding");

endmodule
